FILE: rtl/tcld_pkg.sv
// Package for the text command line decoder.
// Holds the command word table, the command codes and the line control characters.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcld_pkg;

    localparam int WORD_COUNT = 7;
    localparam int WORD_MAX   = 16;

    // Word table order equals the command code order.
    typedef enum logic [2:0] {
        CMD_PING          = 3'd0,
        CMD_LAMPS         = 3'd1,
        CMD_BUZZ_ON       = 3'd2,
        CMD_BUZZ_OFF      = 3'd3,
        CMD_OPEN          = 3'd4,
        CMD_OPEN_OVERRIDE = 3'd5,
        CMD_CLOSE         = 3'd6
    } t_cmd;

    localparam int LED_WORD = 1;

    localparam logic [7:0] CHAR_LF  = 8'd10;
    localparam logic [7:0] CHAR_CR  = 8'd13;
    localparam logic [7:0] CHAR_NUL = 8'd0;
    localparam logic [7:0] CHAR_ONE = 8'h31;

    // Right-aligned text, first character in the highest used byte.
    localparam logic [8*WORD_MAX-1:0] WORD_TXT [WORD_COUNT] = '{
        "PING", "LED:", "BUZZ:1", "BUZZ:0",
        "MOTOR:OPEN", "MOTOR:FORCE_OPEN", "MOTOR:CLOSE"
    };

    localparam int WORD_LEN [WORD_COUNT] = '{4, 4, 6, 6, 10, 16, 11};

    // Character of word w at line position pos (pos below the word length).
    function automatic logic [7:0] word_char(input int w, input logic [3:0] pos);
        logic [8*WORD_MAX-1:0] txt;
        int                    sh;
        txt = WORD_TXT[w];
        sh  = ((WORD_LEN[w] - 1 - int'(pos)) & (WORD_MAX - 1)) * 8;
        word_char = txt[sh +: 8];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/text_command_line_decoder_top.sv
// Text command line decoder: turns a received byte stream into command requests.
// Depends on tcld_pkg (word table, command codes).
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// rx        in         i_rx_valid / o_rx_ready   i_rx_byte
// cmd       out        o_cmd_valid / i_cmd_ready o_command, o_red_lamp, o_yellow_lamp,
//                                                o_green_lamp, o_buzzer_on
//
// One byte per cycle sustained unless a stalled result holds a newline byte; a
// result is valid after its newline byte passes the byte and result registers.
// The byte register feeds one pass of match logic that updates the line state and
// loads the result register in the same cycle.
// Synchronous active-low reset clears the line state, the lamps and the buzzer.
// A stalled result holds only bytes that would produce another result; other bytes
// keep flowing.

module text_command_line_decoder_top #(
    parameter int LINE_BYTES = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_rx_valid,
    output logic                o_rx_ready,
    input  wire  [7:0]          i_rx_byte,
    output logic                o_cmd_valid,
    input  wire                 i_cmd_ready,
    output tcld_pkg::t_cmd      o_command,
    output logic                o_red_lamp,
    output logic                o_yellow_lamp,
    output logic                o_green_lamp,
    output logic                o_buzzer_on
);

    import tcld_pkg::*;

    localparam int KW = $clog2(LINE_BYTES);

    // Byte register
    logic                  r_in_valid;
    logic [7:0]            r_in_byte;

    // Line state
    logic [KW-1:0]         r_kept, n_kept;
    logic [WORD_COUNT-1:0] r_flags, n_flags;
    logic                  r_zero_seen, n_zero_seen;
    logic [2:0]            r_lamp_chars, n_lamp_chars;
    logic [2:0]            r_lamps, n_lamps;
    logic                  r_buzzer, n_buzzer;

    // Result register
    logic                  r_out_valid;
    t_cmd                  r_command;
    logic [2:0]            r_out_lamps;
    logic                  r_out_buzzer;

    logic                  is_lf;
    logic                  take;
    logic                  hit_valid;
    t_cmd                  hit_cmd;
    logic                  produce;
    logic                  advance;

    // Find the lowest-coded flagged word of full length (LED: seven or more kept).
    always_comb begin
        hit_valid = 1'b0;
        hit_cmd   = CMD_PING;
        for (int w = WORD_COUNT - 1; w >= 0; w--) begin
            if (r_flags[w]) begin
                if (w == LED_WORD) begin
                    if (r_kept >= KW'(7)) begin
                        hit_valid = 1'b1;
                        hit_cmd   = t_cmd'(w);
                    end
                end else if (r_kept == KW'(WORD_LEN[w])) begin
                    hit_valid = 1'b1;
                    hit_cmd   = t_cmd'(w);
                end
            end
        end
    end

    assign is_lf   = (r_in_byte == CHAR_LF);
    assign take    = !is_lf && (r_in_byte != CHAR_CR) && !r_zero_seen
                     && (r_kept < KW'(LINE_BYTES - 1));
    assign produce = is_lf && hit_valid;
    // Advance the byte register unless it holds a result that cannot land.
    assign advance = r_in_valid && (!produce || !r_out_valid || i_cmd_ready);
    assign o_rx_ready = !r_in_valid || advance;

    always_comb begin
        n_kept       = r_kept;
        n_flags      = r_flags;
        n_zero_seen  = r_zero_seen;
        n_lamp_chars = r_lamp_chars;
        n_lamps      = r_lamps;
        n_buzzer     = r_buzzer;
        if (is_lf) begin
            if (hit_valid) begin
                case (hit_cmd)
                    CMD_LAMPS:    n_lamps  = r_lamp_chars;
                    CMD_BUZZ_ON:  n_buzzer = 1'b1;
                    CMD_BUZZ_OFF: n_buzzer = 1'b0;
                    default:      ;
                endcase
            end
            // Clear the line for the next one.
            n_kept       = '0;
            n_flags      = '1;
            n_zero_seen  = 1'b0;
            n_lamp_chars = '0;
        end else if (take) begin
            if (r_in_byte == CHAR_NUL) begin
                n_zero_seen = 1'b1;
            end else begin
                for (int w = 0; w < WORD_COUNT; w++) begin
                    if (r_kept < KW'(WORD_LEN[w])
                        && word_char(w, r_kept[3:0]) != r_in_byte) begin
                        n_flags[w] = 1'b0;
                    end
                end
                // Lamp characters sit at positions 4, 5 and 6 (red, yellow, green).
                if (r_in_byte == CHAR_ONE) begin
                    if (r_kept == KW'(4)) n_lamp_chars[2] = 1'b1;
                    if (r_kept == KW'(5)) n_lamp_chars[1] = 1'b1;
                    if (r_kept == KW'(6)) n_lamp_chars[0] = 1'b1;
                end
                n_kept = r_kept + KW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_kept       <= '0;
            r_flags      <= '1;
            r_zero_seen  <= 1'b0;
            r_lamp_chars <= '0;
            r_lamps      <= '0;
            r_buzzer     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_rx_ready) begin
                r_in_valid <= i_rx_valid;
            end
            if (advance) begin
                r_kept       <= n_kept;
                r_flags      <= n_flags;
                r_zero_seen  <= n_zero_seen;
                r_lamp_chars <= n_lamp_chars;
                r_lamps      <= n_lamps;
                r_buzzer     <= n_buzzer;
            end
            if (advance && produce) begin
                r_out_valid <= 1'b1;
            end else if (i_cmd_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (advance && produce) begin
            r_command    <= hit_cmd;
            r_out_lamps  <= n_lamps;
            r_out_buzzer <= n_buzzer;
        end
    end

    assign o_cmd_valid   = r_out_valid;
    assign o_command     = r_command;
    assign o_red_lamp    = r_out_lamps[2];
    assign o_yellow_lamp = r_out_lamps[1];
    assign o_green_lamp  = r_out_lamps[0];
    assign o_buzzer_on   = r_out_buzzer;

`ifndef SYNTHESIS
    a_kept_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept <= KW'(LINE_BYTES - 1))
        else $error("kept count beyond line limit");

    a_line_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && is_lf) |=> (r_kept == '0 && r_flags == '1 && !r_zero_seen))
        else $error("line state not cleared after newline");

    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid |-> (r_out_lamps == r_lamps && r_out_buzzer == r_buzzer))
        else $error("pending result disagrees with lamp or buzzer state");

    a_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid |-> (o_command <= CMD_CLOSE))
        else $error("command code out of range");
`endif

endmodule

`default_nettype wire
